/* rtl/hair_fiber_shading_accumulator_unit_macros.svh */
// assertion macros for the hair shading accumulator
`ifndef HAIR_FIBER_SHADING_ACCUMULATOR_UNIT_MACROS_SVH
`define HAIR_FIBER_SHADING_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HFSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HFSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HFSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define HFSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/hfsa_pkg.sv */
package hfsa_pkg;

    localparam int PC_W       = 7;
    localparam int CNT_W      = 5;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;

    localparam logic [PC_W-1:0] PC_START = 7'd0;
    localparam logic [PC_W-1:0] PC_LIGHT = 7'd16;

    localparam logic [1:0] CFG_GAIN_R = 2'd0;
    localparam logic [1:0] CFG_GAIN_G = 2'd1;
    localparam logic [1:0] CFG_GAIN_B = 2'd2;

    localparam logic [1:0] CH_0 = 2'd0;
    localparam logic [1:0] CH_1 = 2'd1;
    localparam logic [1:0] CH_2 = 2'd2;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [14:0] TAN_ONE    = 15'd16384;

    typedef enum logic [5:0] {
        OP_NOP, OP_LATCH, OP_START, OP_ACC_CLR, OP_ACC_ADD, OP_ACC_LD,
        OP_MUL_SQA, OP_MUL_TA, OP_MUL_TV, OP_MUL_SQTL, OP_MUL_SQTI, OP_MUL_DS,
        OP_MUL_TLTI, OP_MUL_PP, OP_MUL_P4, OP_MUL_SG, OP_MUL_SGD, OP_MUL_TOT,
        OP_SQ_LD_ACC, OP_SQ_LD_ONE, OP_SQ_STEP, OP_LEN_WB, OP_DIV_LD, OP_DIV_STEP,
        OP_TAN_WB, OP_TL_WB, OP_TI_WB, OP_DIFF_WB, OP_SINI_WB, OP_S_WB,
        OP_PW_WB, OP_P4_SAVE, OP_D_WB, OP_SUM_WB, OP_EMIT, OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_stat;

    // sequencer program: start item from PC_START, light item from PC_LIGHT
    function automatic t_cmd prog(input logic [PC_W-1:0] pc);
        t_cmd c;
        c = '{OP_NOP, CH_0};
        case (pc)
            7'd0:  c = '{OP_START,     CH_0};
            7'd1:  c = '{OP_MUL_SQA,   CH_0};
            7'd2:  c = '{OP_ACC_ADD,   CH_0};
            7'd3:  c = '{OP_MUL_SQA,   CH_1};
            7'd4:  c = '{OP_ACC_ADD,   CH_0};
            7'd5:  c = '{OP_MUL_SQA,   CH_2};
            7'd6:  c = '{OP_ACC_ADD,   CH_0};
            7'd7:  c = '{OP_SQ_LD_ACC, CH_0};
            7'd8:  c = '{OP_LEN_WB,    CH_0};
            7'd9:  c = '{OP_DIV_LD,    CH_0};
            7'd10: c = '{OP_TAN_WB,    CH_0};
            7'd11: c = '{OP_DIV_LD,    CH_1};
            7'd12: c = '{OP_TAN_WB,    CH_1};
            7'd13: c = '{OP_DIV_LD,    CH_2};
            7'd14: c = '{OP_TAN_WB,    CH_2};
            7'd15: c = '{OP_END,       CH_0};
            7'd16: c = '{OP_ACC_CLR,   CH_0};
            7'd17: c = '{OP_MUL_TA,    CH_0};
            7'd18: c = '{OP_ACC_ADD,   CH_0};
            7'd19: c = '{OP_MUL_TA,    CH_1};
            7'd20: c = '{OP_ACC_ADD,   CH_0};
            7'd21: c = '{OP_MUL_TA,    CH_2};
            7'd22: c = '{OP_ACC_ADD,   CH_0};
            7'd23: c = '{OP_TL_WB,     CH_0};
            7'd24: c = '{OP_ACC_CLR,   CH_0};
            7'd25: c = '{OP_MUL_TV,    CH_0};
            7'd26: c = '{OP_ACC_ADD,   CH_0};
            7'd27: c = '{OP_MUL_TV,    CH_1};
            7'd28: c = '{OP_ACC_ADD,   CH_0};
            7'd29: c = '{OP_MUL_TV,    CH_2};
            7'd30: c = '{OP_ACC_ADD,   CH_0};
            7'd31: c = '{OP_TI_WB,     CH_0};
            7'd32: c = '{OP_MUL_SQTL,  CH_0};
            7'd33: c = '{OP_SQ_LD_ONE, CH_0};
            7'd34: c = '{OP_DIFF_WB,   CH_0};
            7'd35: c = '{OP_MUL_SQTI,  CH_0};
            7'd36: c = '{OP_SQ_LD_ONE, CH_0};
            7'd37: c = '{OP_SINI_WB,   CH_0};
            7'd38: c = '{OP_MUL_DS,    CH_0};
            7'd39: c = '{OP_ACC_LD,    CH_0};
            7'd40: c = '{OP_MUL_TLTI,  CH_0};
            7'd41: c = '{OP_ACC_ADD,   CH_0};
            7'd42: c = '{OP_S_WB,      CH_0};
            7'd43: c = '{OP_MUL_PP,    CH_0};
            7'd44: c = '{OP_PW_WB,     CH_0};
            7'd45: c = '{OP_MUL_PP,    CH_0};
            7'd46: c = '{OP_PW_WB,     CH_0};
            7'd47: c = '{OP_P4_SAVE,   CH_0};
            7'd48: c = '{OP_MUL_PP,    CH_0};
            7'd49: c = '{OP_PW_WB,     CH_0};
            7'd50: c = '{OP_MUL_PP,    CH_0};
            7'd51: c = '{OP_PW_WB,     CH_0};
            7'd52: c = '{OP_MUL_P4,    CH_0};
            7'd53: c = '{OP_PW_WB,     CH_0};
            7'd54: c = '{OP_MUL_SG,    CH_0};
            7'd55: c = '{OP_MUL_SGD,   CH_0};
            7'd56: c = '{OP_D_WB,      CH_0};
            7'd57: c = '{OP_MUL_TOT,   CH_0};
            7'd58: c = '{OP_SUM_WB,    CH_0};
            7'd59: c = '{OP_MUL_SG,    CH_1};
            7'd60: c = '{OP_MUL_SGD,   CH_1};
            7'd61: c = '{OP_D_WB,      CH_1};
            7'd62: c = '{OP_MUL_TOT,   CH_1};
            7'd63: c = '{OP_SUM_WB,    CH_1};
            7'd64: c = '{OP_MUL_SG,    CH_2};
            7'd65: c = '{OP_MUL_SGD,   CH_2};
            7'd66: c = '{OP_D_WB,      CH_2};
            7'd67: c = '{OP_MUL_TOT,   CH_2};
            7'd68: c = '{OP_SUM_WB,    CH_2};
            7'd69: c = '{OP_END,       CH_0};
            default: c = '{OP_NOP,     CH_0};
        endcase
        return c;
    endfunction

endpackage

/* rtl/hair_fiber_shading_accumulator_unit.sv */
// a new item is taken only in idle, after the previous start or light item has run its whole program;
// the result register is loaded and shown in the cycle after the emit command;
// the run time is set by the 32-step shared square root (one per start, two per light), the 15-step divider
// (three per start) and the single multiplier the sequencer walks through
// a result waits for the sink while the next item is taken; a second result stalls until taken
// reset (synchronous, active low): gains 1.0, tangent, view, color and sums zero
module hair_fiber_shading_accumulator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [191:0] i_s_tdata,  // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y,
                                     // vec_b_z, color_r, color_g, color_b
    input  logic         i_s_tuser,  // req_type
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,  // shade_r, shade_g, shade_b
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import hfsa_pkg::*;
    `include "hair_fiber_shading_accumulator_unit_macros.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    hfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    hfsa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_cmd      (w_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    `HFSA_ASSERT_NXT(a_busy_after_request, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "request taken while busy")
    `HFSA_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, w_cmd.op == OP_EMIT, w_stat.out_free, "result overwritten")
    `HFSA_ASSERT_NXT(a_emit_shows_valid, i_clk, i_rst_n, w_cmd.op == OP_EMIT, o_m_tvalid, "result not presented")

endmodule

/* rtl/hfsa_ctrl.sv */
module hfsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tuser,
    input  hfsa_pkg::t_stat i_stat,
    output logic          o_s_tready,
    output hfsa_pkg::t_cmd  o_cmd
);
    import hfsa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_DIV  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             w_prog;

    assign w_prog = prog(r_pc);

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_cnt      = r_cnt;
        o_cmd      = '{OP_NOP, CH_0};
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd   = '{OP_LATCH, CH_0};
                    n_pc    = i_s_tuser ? PC_LIGHT : PC_START;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd = w_prog;
                if (w_prog.op inside {OP_SQ_LD_ACC, OP_SQ_LD_ONE}) begin
                    n_state = ST_SQRT;
                    n_cnt   = '0;
                    n_pc    = r_pc + 1'b1;
                end else if (w_prog.op == OP_DIV_LD) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                    n_pc    = r_pc + 1'b1;
                end else if (w_prog.op == OP_END) begin
                    o_cmd = '{OP_NOP, CH_0};
                    if (!i_stat.last) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.out_free) begin
                        // hold here until the output slot is free
                        o_cmd   = '{OP_EMIT, CH_0};
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            ST_SQRT: begin
                o_cmd = '{OP_SQ_STEP, CH_0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_DIV: begin
                o_cmd = '{OP_DIV_STEP, CH_0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* rtl/hfsa_dp.sv */
module hfsa_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [191:0]   i_s_tdata,
    input  logic           i_s_tlast,
    input  hfsa_pkg::t_cmd i_cmd,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_m_tready,
    output hfsa_pkg::t_stat o_stat,
    output logic           o_m_tvalid,
    output logic [95:0]    o_m_tdata
);
    import hfsa_pkg::*;

    localparam logic signed [65:0] ACC_ONE = 66'sh0_4000_0000;
    localparam logic [63:0]        Q60_ONE = 64'h1000_0000_0000_0000;
    localparam logic signed [67:0] RND_HALF = 68'sh2000_0000;
    localparam logic [35:0]        S_MAX   = 36'h0_4000_0000;

    // latched item
    logic signed [31:0] r_a [3];
    logic signed [15:0] r_b [3];
    logic [15:0]        r_col [3];
    logic               r_last;

    // shading state
    logic [15:0]        r_gain [3];
    logic signed [15:0] r_tan [3];
    logic signed [15:0] r_view [3];
    logic [15:0]        r_surf [3];
    logic [31:0]        r_sum [3];

    // working registers
    logic signed [67:0] r_prod;
    logic signed [65:0] r_acc;
    logic [63:0]        r_sqv, r_sqr, r_sqbit;
    logic [31:0]        r_len;
    logic [45:0]        r_rem, r_dsub;
    logic [14:0]        r_q;
    logic signed [31:0] r_tl, r_ti;
    logic [30:0]        r_diff, r_sini, r_pw, r_p4;
    logic [32:0]        r_tot;
    logic [95:0]        r_out;
    logic               r_out_vld;

    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic [64:0]        w_sq_try;
    logic [65:0]        w_mag;
    logic signed [67:0] w_rnd;
    logic [42:0]        w_sum;
    logic [14:0]        w_qc;
    logic [1:0]         w_sel;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [65:0] v);
        if (v > ACC_ONE) begin
            return 32'sh4000_0000;
        end else if (v < -ACC_ONE) begin
            return -32'sh4000_0000;
        end
        return v[31:0];
    endfunction

    assign w_sel = i_cmd.sel;

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_MUL_SQA: begin
                w_ma = {2'b00, mag32(r_a[w_sel])};
                w_mb = {2'b00, mag32(r_a[w_sel])};
            end
            OP_MUL_TA: begin
                w_ma = {{18{r_tan[w_sel][15]}}, r_tan[w_sel]};
                w_mb = {{2{r_a[w_sel][31]}}, r_a[w_sel]};
            end
            OP_MUL_TV: begin
                w_ma = {{18{r_tan[w_sel][15]}}, r_tan[w_sel]};
                w_mb = {{18{r_view[w_sel][15]}}, r_view[w_sel]};
            end
            OP_MUL_SQTL: begin
                w_ma = {2'b00, mag32(r_tl)};
                w_mb = {2'b00, mag32(r_tl)};
            end
            OP_MUL_SQTI: begin
                w_ma = {2'b00, mag32(r_ti)};
                w_mb = {2'b00, mag32(r_ti)};
            end
            OP_MUL_DS: begin
                w_ma = {3'b000, r_diff};
                w_mb = {3'b000, r_sini};
            end
            OP_MUL_TLTI: begin
                w_ma = {{2{r_tl[31]}}, r_tl};
                w_mb = {{2{r_ti[31]}}, r_ti};
            end
            OP_MUL_PP: begin
                w_ma = {3'b000, r_pw};
                w_mb = {3'b000, r_pw};
            end
            OP_MUL_P4: begin
                w_ma = {3'b000, r_pw};
                w_mb = {3'b000, r_p4};
            end
            OP_MUL_SG: begin
                w_ma = {18'd0, r_surf[w_sel]};
                w_mb = {18'd0, r_gain[w_sel]};
            end
            OP_MUL_SGD: begin
                w_ma = {2'b00, r_prod[31:0]};
                w_mb = {3'b000, r_diff};
            end
            OP_MUL_TOT: begin
                w_ma = {1'b0, r_tot};
                w_mb = {18'd0, r_col[w_sel]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod   = w_ma * w_mb;
    assign w_sq_try = {1'b0, r_sqr} + {1'b0, r_sqbit};
    assign w_mag    = r_acc[65] ? (~r_acc + 66'd1) : r_acc;
    assign w_rnd    = r_prod + RND_HALF;
    assign w_sum    = {11'd0, r_sum[w_sel]} + {1'b0, r_prod[49:8]};
    assign w_qc     = (r_q > TAN_ONE) ? TAN_ONE : r_q;

    // shading state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_gain[i] <= GAIN_RESET;
                r_tan[i]  <= '0;
                r_view[i] <= '0;
                r_surf[i] <= '0;
                r_sum[i]  <= '0;
            end
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_R: r_gain[0] <= i_cfg_data;
                    CFG_GAIN_G: r_gain[1] <= i_cfg_data;
                    CFG_GAIN_B: r_gain[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_START: begin
                    for (int i = 0; i < 3; i++) begin
                        r_view[i] <= r_b[i];
                        r_surf[i] <= r_col[i];
                        r_sum[i]  <= '0;
                    end
                end
                OP_TAN_WB: begin
                    if (r_len == '0) begin
                        r_tan[w_sel] <= '0;
                    end else if (r_a[w_sel][31]) begin
                        r_tan[w_sel] <= -$signed({1'b0, w_qc});
                    end else begin
                        r_tan[w_sel] <= $signed({1'b0, w_qc});
                    end
                end
                OP_SUM_WB: begin
                    r_sum[w_sel] <= (w_sum[42:32] != '0) ? 32'hFFFF_FFFF : w_sum[31:0];
                end
                default: ;
            endcase
            if (i_cmd.op == OP_EMIT) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (i_cmd.op)
            OP_LATCH: begin
                r_a[0]   <= i_s_tdata[31:0];
                r_a[1]   <= i_s_tdata[63:32];
                r_a[2]   <= i_s_tdata[95:64];
                r_b[0]   <= i_s_tdata[111:96];
                r_b[1]   <= i_s_tdata[127:112];
                r_b[2]   <= i_s_tdata[143:128];
                r_col[0] <= i_s_tdata[159:144];
                r_col[1] <= i_s_tdata[175:160];
                r_col[2] <= i_s_tdata[191:176];
                r_last   <= i_s_tlast;
            end
            OP_START, OP_ACC_CLR: r_acc <= '0;
            OP_ACC_ADD:           r_acc <= r_acc + r_prod[65:0];
            OP_ACC_LD:            r_acc <= r_prod[65:0];
            OP_SQ_LD_ACC: begin
                r_sqv   <= r_acc[63:0];
                r_sqr   <= '0;
                r_sqbit <= 64'h4000_0000_0000_0000;
            end
            OP_SQ_LD_ONE: begin
                // 1 - c^2 in Q60, clamped at zero
                r_sqv   <= (r_prod[67:60] != '0) ? 64'd0 : (Q60_ONE - {4'd0, r_prod[59:0]});
                r_sqr   <= '0;
                r_sqbit <= 64'h4000_0000_0000_0000;
            end
            OP_SQ_STEP: begin
                if ({1'b0, r_sqv} >= w_sq_try) begin
                    r_sqv <= r_sqv - w_sq_try[63:0];
                    r_sqr <= (r_sqr >> 1) + r_sqbit;
                end else begin
                    r_sqr <= r_sqr >> 1;
                end
                r_sqbit <= r_sqbit >> 2;
            end
            OP_LEN_WB: r_len <= r_sqr[31:0];
            OP_DIV_LD: begin
                r_rem  <= {mag32(r_a[w_sel]), 14'd0};
                r_dsub <= {r_len, 14'd0};
                r_q    <= '0;
            end
            OP_DIV_STEP: begin
                if (r_rem >= r_dsub) begin
                    r_rem <= r_rem - r_dsub;
                    r_q   <= {r_q[13:0], 1'b1};
                end else begin
                    r_q   <= {r_q[13:0], 1'b0};
                end
                r_dsub <= r_dsub >> 1;
            end
            OP_TL_WB:   r_tl   <= clamp_q30(r_acc);
            OP_TI_WB:   r_ti   <= clamp_q30(r_acc <<< 2);
            OP_DIFF_WB: r_diff <= r_sqr[30:0];
            OP_SINI_WB: r_sini <= r_sqr[30:0];
            OP_S_WB:    r_pw   <= (w_mag[65:30] > S_MAX) ? S_MAX[30:0] : w_mag[60:30];
            OP_PW_WB:   r_pw   <= w_rnd[60:30];
            OP_P4_SAVE: r_p4   <= r_pw;
            OP_D_WB:    r_tot  <= {1'b0, r_prod[61:30]} + {16'd0, r_pw[30:14]};
            OP_EMIT:    r_out  <= {r_sum[2], r_sum[1], r_sum[0]};
            default: ;
        endcase
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_vld || i_m_tready;
    assign o_m_tvalid      = r_out_vld;
    assign o_m_tdata       = r_out;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import hfsa_pkg::*;

    typedef enum logic {REQ_START = 1'b0, REQ_LIGHT = 1'b1} t_req;

    typedef struct packed {
        t_req        kind;
        logic [31:0] ax, ay, az;
        logic [15:0] bx, by, bz;
        logic [15:0] cr, cg, cb;
        logic        last;
    } t_request;

    typedef struct {
        t_request    rq;
        logic        known;
        logic [31:0] er, eg, eb;
    } t_row;

    localparam int LIGHT_CYCLES = 130;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;
    logic         i_s_tuser;
    logic         i_s_tlast;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [95:0]  o_m_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [15:0]  i_cfg_data;

    hair_fiber_shading_accumulator_unit i_dut (.*);

    // predictor state
    logic [15:0]        gain_q88 [3];
    logic signed [15:0] tan_q14 [3];
    logic signed [15:0] view_q14 [3];
    logic [15:0]        surf_q88 [3];
    logic [31:0]        shade_sum [3];

    logic [95:0] shade_queue [$];
    int          mismatches;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] clip_one(input logic signed [63:0] v);
        if (v > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
        if (v < -(64'sd1 <<< 30)) return -(64'sd1 <<< 30);
        return v;
    endfunction

    function automatic logic [63:0] sine_q30(input logic signed [63:0] c);
        logic [63:0] sq;
        sq = mag(c) * mag(c);
        return root64(sq >= (64'd1 << 60) ? 64'd0 : (64'd1 << 60) - sq);
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // updates shading state, returns 1 when the request emits sums
    function automatic bit shade_model(input t_request rq, output logic [95:0] res);
        logic signed [63:0] a [3];
        logic [15:0] lc [3];
        logic [63:0] len2, len, m, diff, sini, s, p2, p4, p8, p16, spec, sg, d, tot, add, sum;
        logic signed [63:0] tl, ti, base;
        a[0] = $signed(rq.ax); a[1] = $signed(rq.ay); a[2] = $signed(rq.az);
        lc[0] = rq.cr; lc[1] = rq.cg; lc[2] = rq.cb;
        if (rq.kind == REQ_START) begin
            len2 = 0;
            for (int i = 0; i < 3; i++) len2 += mag(a[i]) * mag(a[i]);
            len = root64(len2);
            for (int i = 0; i < 3; i++) begin
                if (len == 0) begin
                    tan_q14[i] = 0;
                end else begin
                    m = (mag(a[i]) << 14) / len;
                    if (m > 16384) m = 16384;
                    tan_q14[i] = a[i] < 0 ? -m[15:0] : m[15:0];
                end
                surf_q88[i] = lc[i];
                shade_sum[i] = 0;
            end
            view_q14[0] = rq.bx; view_q14[1] = rq.by; view_q14[2] = rq.bz;
        end else begin
            tl = 0;
            ti = 0;
            for (int i = 0; i < 3; i++) begin
                tl += 64'(tan_q14[i]) * a[i];
                ti += 64'(tan_q14[i]) * 64'(view_q14[i]);
            end
            tl = clip_one(tl);
            ti = clip_one(ti * 4);
            diff = sine_q30(tl);
            sini = sine_q30(ti);
            base = $signed(diff * sini) + tl * ti;
            s = mag(base) >> 30;
            if (s > (64'd1 << 30)) s = 64'd1 << 30;
            p2 = qmul(s, s);
            p4 = qmul(p2, p2);
            p8 = qmul(p4, p4);
            p16 = qmul(p8, p8);
            spec = qmul(p16, p4);
            for (int i = 0; i < 3; i++) begin
                sg = 64'(surf_q88[i]) * 64'(gain_q88[i]);
                d = (sg * diff) >> 30;
                tot = d + (spec >> 14);
                add = (tot * 64'(lc[i])) >> 8;
                sum = 64'(shade_sum[i]) + add;
                shade_sum[i] = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
            end
        end
        res = {shade_sum[2], shade_sum[1], shade_sum[0]};
        return rq.last;
    endfunction

    task automatic report(input string what, input logic [95:0] got, input logic [95:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic set_gain(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        gain_q88[idx] = val;
    endtask

    task automatic send(input t_request rq);
        logic [95:0] res;
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= rq.kind;
        i_s_tlast <= rq.last;
        i_s_tdata <= {rq.cb, rq.cg, rq.cr, rq.bz, rq.by, rq.bx, rq.az, rq.ay, rq.ax};
        do @(posedge i_clk); while (!o_s_tready);
        if (shade_model(rq, res)) shade_queue.push_back(res);
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (shade_queue.size() != 0) @(posedge i_clk);
        repeat (LIGHT_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] view_comp;
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h8000;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] vec_comp(input bit unit);
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'd0;
            default: return unit ? 32'($signed($urandom_range(0, 131072)) - 65536)
                                 : 32'($signed($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic t_request rand_req(input t_req kind, input logic last);
        t_request rq;
        bit unit;
        unit = kind == REQ_LIGHT;
        rq.kind = kind;
        rq.ax = vec_comp(unit); rq.ay = vec_comp(unit); rq.az = vec_comp(unit);
        rq.bx = view_comp(); rq.by = view_comp(); rq.bz = view_comp();
        rq.cr = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 512));
        rq.cg = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 512));
        rq.cb = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 512));
        rq.last = last;
        return rq;
    endfunction

    t_row rows [$];

    task automatic add_row(input t_req k, input logic [31:0] ax, ay, az,
                           input logic [15:0] bx, by, bz, cr, cg, cb, input logic last,
                           input logic known = 0, input logic [31:0] er = 0, eg = 0, eb = 0);
        t_row r;
        r.rq = '{k, ax, ay, az, bx, by, bz, cr, cg, cb, last};
        r.known = known; r.er = er; r.eg = eg; r.eb = eb;
        rows.push_back(r);
    endtask

    // sink side
    initial begin
        logic [95:0] want;
        int gap;
        i_m_tready = 1'b1;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
            if (shade_queue.size() == 0) begin
                report("unexpected result", o_m_tdata, 'x);
            end else begin
                want = shade_queue.pop_front();
                if (o_m_tdata[31:0] !== want[31:0])
                    report("shade_r", o_m_tdata, want);
                if (o_m_tdata[63:32] !== want[63:32])
                    report("shade_g", o_m_tdata, want);
                if (o_m_tdata[95:64] !== want[95:64])
                    report("shade_b", o_m_tdata, want);
            end
        end
    end

    initial begin
        #60ms;
        $display("** hair_fiber_shading_accumulator_unit: FAILED **");
        $finish;
    end

    initial begin
        t_row r;
        int lights;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_s_tlast = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_GAIN_R;
        i_cfg_data = '0;
        mismatches = 0;
        for (int i = 0; i < 3; i++) begin
            gain_q88[i] = GAIN_RESET;
            tan_q14[i] = 0; view_q14[i] = 0; surf_q88[i] = 0; shade_sum[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // light before any start: zero tangent and zero surface, spec = 1
        // gives 2^16 * light / 2^8 per channel
        add_row(REQ_LIGHT, 0, 0, 0, 0, 0, 0, 256, 512, 16'hFFFF, 1,
                1, 32'h10000, 32'h20000, 32'hFFFF00);
        add_row(REQ_START, 32'h7FFF_FFFF, 0, 0, 16384, 0, 0, 16'hFFFF, 0, 256, 1, 1, 0, 0, 0);
        add_row(REQ_LIGHT, 32'h10000, 0, 0, 0, 0, 0, 256, 256, 256, 0);
        add_row(REQ_LIGHT, 0, 32'h10000, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        add_row(REQ_START, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        add_row(REQ_LIGHT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        add_row(REQ_LIGHT, 32'hFFFF_0000, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        add_row(REQ_LIGHT, 0, 0, 32'h10000, 0, 0, 0, 100, 200, 300, 1);
        add_row(REQ_START, 0, 0, 0, 0, 16384, 0, 256, 256, 256, 0);
        add_row(REQ_LIGHT, 32'h0000B505, 32'h0000B505, 0, 0, 0, 0, 256, 256, 256, 1);
        add_row(REQ_START, 32'h00001234, 32'hFFFF8000, 32'h00030000,
                -16'sd16384, 16'h1000, 16'h2000, 16'h0180, 16'h0040, 16'h8000, 0);
        add_row(REQ_LIGHT, 32'h00008000, 32'hFFFF0000, 32'h00004000, 0, 0, 0,
                16'h0200, 16'h0100, 16'h0080, 1);
        foreach (rows[k]) begin
            r = rows[k];
            if (r.known) begin
                drain();
                send(r.rq);
                shade_queue[$] = {r.eb, r.eg, r.er};
            end else begin
                send(r.rq);
            end
        end

        // configuration phases, extremes among them
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            for (int c = 0; c < 3; c++) begin
                case (phase)
                    0: set_gain(c[1:0], 16'd0);
                    1: set_gain(c[1:0], 16'hFFFF);
                    2: set_gain(c[1:0], GAIN_RESET);
                    default: set_gain(c[1:0], 16'($urandom));
                endcase
            end
            i_cfg_we <= 1'b0;
            for (int n = 0; n < 300; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send(rand_req(t_req'($urandom_range(0, 1)), $urandom_range(0, 1)));
                end else begin
                    lights = $urandom_range(0, 4);
                    send(rand_req(REQ_START, lights == 0));
                    for (int j = 0; j < lights; j++)
                        send(rand_req(REQ_LIGHT, j == lights - 1));
                    n += lights;
                end
            end
        end
        drain();
        if (mismatches == 0) begin
            $display("** hair_fiber_shading_accumulator_unit: PASSED **");
        end else begin
            $display("** hair_fiber_shading_accumulator_unit: FAILED **");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/hfsa_pkg.sv
rtl/hfsa_ctrl.sv
rtl/hfsa_dp.sv
rtl/hair_fiber_shading_accumulator_unit.sv
tb/testbench.sv
